// ===== rtl/core/salted_word_string_hash_macros.svh =====
// assertion macros used by the checker file of the string hash block
`ifndef SALTED_WORD_STRING_HASH_MACROS_SVH
`define SALTED_WORD_STRING_HASH_MACROS_SVH

// condition and consequence in the same cycle
`define SHS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/shs_pkg.sv =====
// shared types and constants of the salted word string hash
package shs_pkg;

	localparam int WORD_W     = 64;
	localparam int HALF_W     = 32;
	localparam int COUNT_W    = 4;
	localparam int HASH_W     = 32;
	localparam int ADDR_W     = 4;
	localparam int ROT_X      = 12;
	localparam int ROT_Y      = 45;
	localparam int MIX_SHIFT  = 3;
	localparam int HASH_SHIFT = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WORD_W-1:0] FOLD_RESET = 64'h61C8_8646_80B5_83EB;

	localparam logic REG_SALT = 1'b0;
	localparam logic REG_FOLD = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              full;
		logic              ends;
	} shs_item_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} shs_fold_req_t;

	typedef enum logic [1:0] {
		FOLD_IDLE,
		FOLD_MUL,
		FOLD_DONE
	} shs_fold_state_t;

endpackage

// ===== rtl/core/shs_front.sv =====
// front end: saturates the byte count, masks tail bytes and marks string ends
module shs_front (
	input  logic [shs_pkg::WORD_W-1:0]  word,
	input  logic [shs_pkg::COUNT_W-1:0] byte_count,
	input  logic                        last,
	output shs_pkg::shs_item_t          item
);

	logic [shs_pkg::WORD_W-1:0] mask;
	logic                       full;

	// eight or more bytes is a full word
	assign full = byte_count[shs_pkg::COUNT_W-1];

	always_comb begin
		for (int i = 0; i < shs_pkg::WORD_W / 8; i++) begin
			mask[i*8 +: 8] = (full || (i < int'(byte_count[shs_pkg::COUNT_W-2:0]))) ?
				8'hFF : 8'h00;
		end
	end

	always_comb begin
		item.word = word & mask;
		item.full = full;
		item.ends = full ? last : 1'b1;
	end

endmodule

// ===== rtl/core/shs_queue.sv =====
// short item queue between the front end and the mixing engine
module shs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  shs_pkg::shs_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output shs_pkg::shs_item_t head_item
);

	localparam int PtrW = (shs_pkg::QUEUE_DEPTH > 1) ? $clog2(shs_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(shs_pkg::QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(shs_pkg::QUEUE_DEPTH - 1);

	shs_pkg::shs_item_t entry_q [shs_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CntW'(shs_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/shs_back.sv =====
// mixing engine: one full word mixed or one tail folded in per cycle; a string end waits while the fold unit is busy
module shs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [shs_pkg::WORD_W-1:0] salt,
	input  logic                       item_valid,
	input  shs_pkg::shs_item_t         item,
	input  logic                       fold_idle,
	output logic                       item_pop,
	output shs_pkg::shs_fold_req_t     fold_req
);

	localparam int W = shs_pkg::WORD_W;

	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic         start_q;
	logic [W-1:0] x0, y0, xa, yb, xr, xs, yr, ym;
	logic [W-1:0] x_new, y_new;

	always_comb begin
		x0 = start_q ? '0 : x_q;
		y0 = start_q ? salt : y_q;
		xa = x0 ^ item.word;
		yb = y0 ^ xa;
		xr = {xa[W-1-shs_pkg::ROT_X:0], xa[W-1:W-shs_pkg::ROT_X]};
		xs = xr + yb;
		yr = {yb[W-1-shs_pkg::ROT_Y:0], yb[W-1:W-shs_pkg::ROT_Y]};
		// times nine
		ym = (yr << shs_pkg::MIX_SHIFT) + yr;
		x_new = item.full ? xs : xa;
		y_new = item.full ? ym : y0;
	end

	// a string end waits until the fold unit is free
	assign item_pop = item_valid && (!item.ends || fold_idle);

	always_comb begin
		fold_req.start = item_pop && item.ends;
		fold_req.x     = x_new;
		fold_req.y     = y_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (item_pop) begin
			start_q <= item.ends;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			x_q <= x_new;
			y_q <= y_new;
		end
	end

endmodule

// ===== rtl/core/shs_fold.sv =====
// final fold on one shared 32x32 multiplier, with the output register
module shs_fold (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [shs_pkg::WORD_W-1:0]  mult,
	input  shs_pkg::shs_fold_req_t      req,
	output logic                        idle,
	output logic [shs_pkg::HASH_W-1:0]  hash,
	output logic                        hash_valid,
	input  logic                        hash_stall
);

	localparam int W = shs_pkg::WORD_W;
	localparam int H = shs_pkg::HALF_W;

	shs_pkg::shs_fold_state_t state_q, state_d;

	logic [2:0]                  step_q;
	logic [1:0]                  sub;
	logic                        pass;
	logic [W-1:0]                a_q;
	logic [W-1:0]                y_q;
	logic [W-1:0]                acc_q;
	logic [W-1:0]                prod_q;
	logic [shs_pkg::HASH_W-1:0]  res_q;
	logic [shs_pkg::HASH_W-1:0]  hash_q;
	logic                        hash_valid_q;
	logic [H-1:0]                op_a, op_b;
	logic [W-1:0]                low;
	logic                        load_out;
	logic                        take_job;

	assign sub  = step_q[1:0];
	assign pass = step_q[2];

	// low half of a times mult from three partial products
	always_comb begin
		op_a = (sub[1]) ? a_q[W-1:H] : a_q[H-1:0];
		op_b = (sub == 2'd1) ? mult[W-1:H] : mult[H-1:0];
		low  = {acc_q[W-1:H] + prod_q[H-1:0], acc_q[H-1:0]};
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		take_job = 1'b0;
		unique case (state_q)
			shs_pkg::FOLD_IDLE: begin
				if (req.start) begin
					take_job = 1'b1;
					state_d  = shs_pkg::FOLD_MUL;
				end
			end
			shs_pkg::FOLD_MUL: begin
				if (step_q == 3'd7) begin
					state_d = shs_pkg::FOLD_DONE;
				end
			end
			shs_pkg::FOLD_DONE: begin
				if (!hash_valid_q || !hash_stall) begin
					load_out = 1'b1;
					state_d  = shs_pkg::FOLD_IDLE;
				end
			end
			default: begin
				state_d = shs_pkg::FOLD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::FOLD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			hash_valid_q <= 1'b0;
		end else begin
			if (take_job) begin
				step_q <= '0;
			end else if (state_q == shs_pkg::FOLD_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				hash_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				hash_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			a_q <= req.x;
			y_q <= req.y;
		end else if (state_q == shs_pkg::FOLD_MUL) begin
			prod_q <= op_a * op_b;
			priority case (sub)
				2'd1: acc_q <= prod_q;
				2'd2: acc_q[W-1:H] <= acc_q[W-1:H] + prod_q[H-1:0];
				2'd3: begin
					if (!pass) begin
						a_q <= y_q ^ low;
					end else begin
						res_q <= low[shs_pkg::HASH_SHIFT +: shs_pkg::HASH_W];
					end
				end
				default: begin
				end
			endcase
		end
		if (load_out) begin
			hash_q <= res_q;
		end
	end

	assign idle       = (state_q == shs_pkg::FOLD_IDLE);
	assign hash       = hash_q;
	assign hash_valid = hash_valid_q;

endmodule

// ===== rtl/core/salted_word_string_hash.sv =====
// top level of the salted word string hash
// Takes one string word per cycle while word_stall is low: a full word is mixed,
// a tail is folded in the same way, so words of a string stream at one item per
// clock while the queue has room. A string end starts the final fold on one
// shared 32x32 multiplier: two 64-bit products in turn, then a load of the output
// register once it is free. A second string end reaching the mixing engine while
// the fold unit is still busy waits there; a two-item queue keeps the input open
// meanwhile. salt and fold_multiplier sit at byte addresses 0 and 8.
module salted_word_string_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [shs_pkg::WORD_W-1:0]  word,
	input  logic [shs_pkg::COUNT_W-1:0] byte_count,
	input  logic                        last,
	input  logic                        word_valid,
	output logic                        word_stall,
	output logic [shs_pkg::HASH_W-1:0]  hash,
	output logic                        hash_valid,
	input  logic                        hash_stall,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [shs_pkg::ADDR_W-1:0]  paddr,
	input  logic [shs_pkg::WORD_W-1:0]  pwdata,
	output logic [shs_pkg::WORD_W-1:0]  prdata,
	output logic                        pready
);

	logic [shs_pkg::WORD_W-1:0] salt_q;
	logic [shs_pkg::WORD_W-1:0] fold_mult_q;
	logic                       reg_sel;

	shs_pkg::shs_item_t     front_item;
	shs_pkg::shs_item_t     head_item;
	shs_pkg::shs_fold_req_t fold_req;
	logic                   queue_full;
	logic                   queue_not_empty;
	logic                   item_pop;
	logic                   fold_idle;

	// registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[shs_pkg::ADDR_W-1];
	assign prdata  = (reg_sel == shs_pkg::REG_FOLD) ? fold_mult_q : salt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q      <= '0;
			fold_mult_q <= shs_pkg::FOLD_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				shs_pkg::REG_SALT: salt_q      <= pwdata;
				shs_pkg::REG_FOLD: fold_mult_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	shs_front u_front (
		.word       (word),
		.byte_count (byte_count),
		.last       (last),
		.item       (front_item)
	);

	shs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (word_valid),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (item_pop),
		.not_empty (queue_not_empty),
		.head_item (head_item)
	);

	assign word_stall = queue_full;

	shs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.salt       (salt_q),
		.item_valid (queue_not_empty),
		.item       (head_item),
		.fold_idle  (fold_idle),
		.item_pop   (item_pop),
		.fold_req   (fold_req)
	);

	shs_fold u_fold (
		.clk        (clk),
		.arst_n     (arst_n),
		.mult       (fold_mult_q),
		.req        (fold_req),
		.idle       (fold_idle),
		.hash       (hash),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall)
	);

endmodule

// ===== rtl/core/shs_checker.sv =====
// port checker for the salted word string hash, bound to the top level
`include "salted_word_string_hash_macros.svh"

module shs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic [shs_pkg::HASH_W-1:0]  hash,
	input logic                        hash_valid,
	input logic                        hash_stall,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [shs_pkg::ADDR_W-1:0]  paddr,
	input logic [shs_pkg::WORD_W-1:0]  pwdata,
	input logic [shs_pkg::WORD_W-1:0]  prdata,
	input logic                        pready
);

	`SHS_ASSERT_NEXT(a_hash_hold, hash_valid && hash_stall, hash_valid && $stable(hash), "stalled hash item changed")
	`SHS_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")
	`SHS_ASSERT_NEXT(a_reg_readback, psel && penable && pwrite && pready, !psel || pwrite || (paddr[shs_pkg::ADDR_W-1] != $past(paddr[shs_pkg::ADDR_W-1])) || (prdata == $past(pwdata)), "register read does not return the value just written")

endmodule

bind salted_word_string_hash shs_checker u_shs_checker (.*);
